[rtl/core/plinterp_pkg.sv]
// Shared types, constants and helpers for the piecewise linear interpolator.
`default_nettype none
package plinterp_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 1'b1;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	localparam logic [1:0] REGION_EMPTY = 2'd0;
	localparam logic [1:0] REGION_LOW = 2'd1;
	localparam logic [1:0] REGION_INT = 2'd2;
	localparam logic [1:0] REGION_HIGH = 2'd3;

	localparam logic [31:0] SCALE_RESET = 32'd65536;

	localparam logic signed [50:0] LIM48 = 51'sh1_0000_0000_0000;

	localparam int ARITH_AW = 66;
	localparam int ARITH_BW = 33;
	localparam int PROD_W = 82;
	localparam int MUL_STEPS = 33;
	localparam int DIV_STEPS = 66;
	localparam int STEP_W = 7;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} arith_op_t;

	typedef struct packed {
		logic start;
		arith_op_t op;
		logic [ARITH_AW-1:0] a;
		logic [ARITH_BW-1:0] b;
	} arith_req_t;

	typedef struct packed {
		logic [31:0] value;
		logic sat;
	} scaled_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SEL,
		ST_PT_RD,
		ST_PT_CAP,
		ST_IV_RD1,
		ST_IV_RD2,
		ST_IV_CAP,
		ST_SPAN,
		ST_MT_GO,
		ST_MT_WAIT,
		ST_DT_GO,
		ST_DT_WAIT,
		ST_DR_GO,
		ST_DR_WAIT,
		ST_FD,
		ST_MV_GO,
		ST_MV_WAIT,
		ST_MS_GO,
		ST_MS_WAIT,
		ST_DONE
	} seq_state_t;

	function automatic logic [32:0] mag33(input logic [32:0] v);
		mag33 = v[32] ? 33'(-v) : v;
	endfunction

	// floor(+-m / 2^16) clipped to 32 bits signed
	function automatic scaled_t scale_sat(input logic [PROD_W-1:0] m, input logic neg);
		logic [65:0] hi;
		logic [66:0] up;
		scaled_t r;
		hi = m[PROD_W-1:16];
		up = {1'b0, hi} + 67'(m[15:0] != 16'd0);
		if (!neg) begin
			if (hi > 66'h7FFF_FFFF) begin
				r.value = 32'h7FFF_FFFF;
				r.sat = 1'b1;
			end else begin
				r.value = hi[31:0];
				r.sat = 1'b0;
			end
		end else begin
			if (up > 67'h8000_0000) begin
				r.value = 32'h8000_0000;
				r.sat = 1'b1;
			end else begin
				r.value = 32'(-up[31:0]);
				r.sat = 1'b0;
			end
		end
		scale_sat = r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/piecewise_linear_interpolator_top.sv]
// Top level: sequencer, configuration registers and output register.
//
// Input channel (in_valid/in_stall) carries one request: func selects a
// breakpoint write (point_index, point_x, point_y) or an evaluation at
// query_x. Output channel (out_valid/out_stall) returns value, slope,
// region and saturated for each evaluation; writes return nothing.
// Configuration (cfg_we/cfg_index/cfg_data) sets point_count and
// scale_factor; write it only while no evaluation is in flight.
// A write request leaves the sequencer idle. An evaluation with an empty
// table needs one multiply; a clamped result adds a binary search of up
// to 9 steps, a table read and a slope multiply; an interior point needs
// the search, two table reads, a multiply and two divides before the value
// and slope multiplies. The next request can be taken in the cycle after the
// result is loaded. The cost is set by the bit-serial arithmetic unit, one request at a time.
// in_stall is high from an accepted evaluation until its result moves into
// the output register; a result held by out_stall blocks the next one only
// at that hand-off.
// Reset clears control state, sets point_count to 0 and scale_factor to
// 1.0; table contents are undefined until written.
`default_nettype none
module piecewise_linear_interpolator_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                func,
	input  wire logic [7:0]                          point_index,
	input  wire logic [31:0]                         point_x,
	input  wire logic [31:0]                         point_y,
	input  wire logic [31:0]                         query_x,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [31:0]                              value,
	output logic [31:0]                              slope,
	output logic [1:0]                               region,
	output logic                                     saturated,
	input  wire logic                                cfg_we,
	input  wire logic [plinterp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                         cfg_data
);
	import plinterp_pkg::*;

	seq_state_t state_q, state_d;

	logic [8:0] pc_q;
	logic [31:0] scale_q;

	logic [CW-1:0] n_q, lo_q, len_q;
	logic [AW-1:0] addr_q;
	logic [31:0] q_q, x1_q, y1_q, x2_q, y2_q;
	logic [32:0] mdx_q, mdf_q, mdq_q;
	logic negt_q, dneg_q;
	logic [65:0] prod_q;
	logic [48:0] t_q, r_q;
	logic signed [49:0] f_q, d_q;
	logic [1:0] region_q;
	logic [31:0] val_q, slp_q;
	logic sat_q;

	logic out_valid_q;
	logic [31:0] value_q, slope_q;
	logic [1:0] region_out_q;
	logic sat_out_q;

	logic accept;
	logic mem_we;
	logic [AW-1:0] raddr;
	logic [31:0] rd_x, rd_y;
	logic [CW-1:0] n_now, half, probe, ix_m1;
	logic x_below;
	logic [32:0] dx, df, dq;
	logic [32:0] smag;
	logic [49:0] fmag, dmag;
	logic signed [50:0] y1e, te, fsum, fclamp;
	logic signed [49:0] re, dval;
	arith_req_t ar_req;
	logic ar_done;
	logic [PROD_W-1:0] ar_res;
	scaled_t sv;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign mem_we = accept && (func == FUNC_WRITE) && (32'(point_index) < TABLE_DEPTH);

	assign n_now = (32'(pc_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(pc_q);
	assign half = len_q >> 1;
	assign probe = lo_q + half;
	assign ix_m1 = lo_q - 1'b1;
	assign x_below = $signed(rd_x) < $signed(q_q);

	assign dx = {x2_q[31], x2_q} - {x1_q[31], x1_q};
	assign df = {y2_q[31], y2_q} - {y1_q[31], y1_q};
	assign dq = {q_q[31], q_q} - {x1_q[31], x1_q};

	assign smag = mag33({scale_q[31], scale_q});
	assign fmag = f_q[49] ? 50'(-f_q) : 50'(f_q);
	assign dmag = d_q[49] ? 50'(-d_q) : 50'(d_q);

	assign y1e = 51'($signed(y1_q));
	assign te = $signed({2'b00, t_q});
	assign fsum = negt_q ? y1e - te : y1e + te;
	assign fclamp = (fsum > LIM48) ? LIM48 : ((fsum < -LIM48) ? -LIM48 : fsum);
	assign re = $signed({1'b0, r_q});
	assign dval = dneg_q ? -re : re;

	assign sv = scale_sat(ar_res, ((state_q == ST_MS_WAIT) ? d_q[49] : f_q[49]) ^ scale_q[31]);

	plinterp_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(point_index)),
		.wx    (point_x),
		.wy    (point_y),
		.raddr (raddr),
		.rd_x  (rd_x),
		.rd_y  (rd_y)
	);

	plinterp_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ar_req),
		.done   (ar_done),
		.result (ar_res)
	);

	always_comb begin
		state_d = state_q;
		raddr = '0;
		ar_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_EVAL) begin
					state_d = (n_now == '0) ? ST_MV_GO : ST_SRCH_RD;
				end
			end
			ST_SRCH_RD: begin
				raddr = probe[AW-1:0];
				state_d = (len_q == '0) ? ST_SEL : ST_SRCH_CMP;
			end
			ST_SRCH_CMP: state_d = ST_SRCH_RD;
			ST_SEL: begin
				state_d = (lo_q == '0 || lo_q >= n_q) ? ST_PT_RD : ST_IV_RD1;
			end
			ST_PT_RD: begin
				raddr = addr_q;
				state_d = ST_PT_CAP;
			end
			ST_PT_CAP: state_d = ST_MV_GO;
			ST_IV_RD1: begin
				raddr = ix_m1[AW-1:0];
				state_d = ST_IV_RD2;
			end
			ST_IV_RD2: begin
				raddr = lo_q[AW-1:0];
				state_d = ST_IV_CAP;
			end
			ST_IV_CAP: state_d = ST_SPAN;
			ST_SPAN: state_d = (dx == '0) ? ST_MV_GO : ST_MT_GO;
			ST_MT_GO: begin
				ar_req.start = 1'b1;
				ar_req.op = OP_MUL;
				ar_req.a = ARITH_AW'(mdf_q);
				ar_req.b = mdq_q;
				state_d = ST_MT_WAIT;
			end
			ST_MT_WAIT: if (ar_done) state_d = ST_DT_GO;
			ST_DT_GO: begin
				ar_req.start = 1'b1;
				ar_req.op = OP_DIV;
				ar_req.a = prod_q;
				ar_req.b = mdx_q;
				state_d = ST_DT_WAIT;
			end
			ST_DT_WAIT: if (ar_done) state_d = ST_DR_GO;
			ST_DR_GO: begin
				ar_req.start = 1'b1;
				ar_req.op = OP_DIV;
				ar_req.a = ARITH_AW'({mdf_q, 16'h0000});
				ar_req.b = mdx_q;
				state_d = ST_DR_WAIT;
			end
			ST_DR_WAIT: if (ar_done) state_d = ST_FD;
			ST_FD: state_d = ST_MV_GO;
			ST_MV_GO: begin
				ar_req.start = 1'b1;
				ar_req.op = OP_MUL;
				ar_req.a = ARITH_AW'(fmag);
				ar_req.b = smag;
				state_d = ST_MV_WAIT;
			end
			ST_MV_WAIT: begin
				if (ar_done) begin
					state_d = (region_q == REGION_EMPTY) ? ST_DONE : ST_MS_GO;
				end
			end
			ST_MS_GO: begin
				ar_req.start = 1'b1;
				ar_req.op = OP_MUL;
				ar_req.a = ARITH_AW'(dmag);
				ar_req.b = smag;
				state_d = ST_MS_WAIT;
			end
			ST_MS_WAIT: if (ar_done) state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POINT_COUNT: pc_q <= cfg_data[8:0];
				CFG_SCALE_FACTOR: scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_EVAL) begin
					q_q <= query_x;
					n_q <= n_now;
					lo_q <= '0;
					len_q <= (n_now >= CW'(2)) ? n_now : '0;
					f_q <= 50'($signed(query_x));
					d_q <= '0;
					region_q <= REGION_EMPTY;
				end
			end
			ST_SRCH_CMP: begin
				if (x_below) begin
					lo_q <= probe + 1'b1;
					len_q <= len_q - half - 1'b1;
				end else begin
					len_q <= half;
				end
			end
			ST_SEL: begin
				if (lo_q == '0) begin
					addr_q <= '0;
					region_q <= REGION_LOW;
				end else if (lo_q >= n_q) begin
					addr_q <= AW'(n_q - 1'b1);
					region_q <= REGION_HIGH;
				end else begin
					region_q <= REGION_INT;
				end
			end
			ST_PT_CAP: begin
				f_q <= 50'($signed(rd_y));
				d_q <= '0;
			end
			ST_IV_RD2: begin
				x1_q <= rd_x;
				y1_q <= rd_y;
			end
			ST_IV_CAP: begin
				x2_q <= rd_x;
				y2_q <= rd_y;
			end
			ST_SPAN: begin
				mdx_q <= mag33(dx);
				mdf_q <= mag33(df);
				mdq_q <= mag33(dq);
				negt_q <= (df[32] ^ dq[32]) ^ dx[32];
				dneg_q <= df[32] ^ dx[32];
				f_q <= 50'($signed(y1_q));
				d_q <= '0;
			end
			ST_MT_WAIT: if (ar_done) prod_q <= ar_res[65:0];
			ST_DT_WAIT: begin
				if (ar_done) begin
					t_q <= (ar_res[65:0] > 66'h1_0000_0000_0000) ? 49'h1_0000_0000_0000
					                                             : ar_res[48:0];
				end
			end
			ST_DR_WAIT: if (ar_done) r_q <= ar_res[48:0];
			ST_FD: begin
				f_q <= fclamp[49:0];
				d_q <= dval;
			end
			ST_MV_WAIT: begin
				if (ar_done) begin
					val_q <= sv.value;
					sat_q <= sv.sat;
					slp_q <= scale_q;
				end
			end
			ST_MS_WAIT: begin
				if (ar_done) begin
					slp_q <= sv.value;
					sat_q <= sat_q | sv.sat;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			value_q <= val_q;
			slope_q <= slp_q;
			region_out_q <= region_q;
			sat_out_q <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign slope = slope_q;
	assign region = region_out_q;
	assign saturated = sat_out_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ar_done |-> (state_q == ST_MT_WAIT || state_q == ST_DT_WAIT ||
		             state_q == ST_DR_WAIT || state_q == ST_MV_WAIT ||
		             state_q == ST_MS_WAIT))
		else $error("arith done outside a wait state");

	a_clamp_flat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (region == REGION_LOW || region == REGION_HIGH) |-> slope == 32'd0)
		else $error("clamped result with nonzero slope");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside done state");

endmodule
`default_nettype wire

[rtl/core/plinterp_mem.sv]
// Breakpoint table memory: one write port, one registered read port.
`default_nettype none
module plinterp_mem (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [plinterp_pkg::AW-1:0] waddr,
	input  wire logic [31:0]               wx,
	input  wire logic [31:0]               wy,
	input  wire logic [plinterp_pkg::AW-1:0] raddr,
	output logic [31:0]                    rd_x,
	output logic [31:0]                    rd_y
);
	import plinterp_pkg::*;

	logic [31:0] mem_x [TABLE_DEPTH];
	logic [31:0] mem_y [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_x[waddr] <= wx;
			mem_y[waddr] <= wy;
		end
		rd_x <= mem_x[raddr];
		rd_y <= mem_y[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/plinterp_arith.sv]
// Bit-serial shift-add multiplier and restoring divider, unsigned operands.
`default_nettype none
module plinterp_arith (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire plinterp_pkg::arith_req_t      req,
	output logic                               done,
	output logic [plinterp_pkg::PROD_W-1:0]    result
);
	import plinterp_pkg::*;

	logic busy_q;
	logic done_q;
	arith_op_t op_q;
	logic [STEP_W-1:0] cnt_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] mcand_q;
	logic [ARITH_BW-1:0] mplier_q;
	logic [ARITH_AW-1:0] num_q;
	logic [ARITH_BW:0] rem_q;
	logic [ARITH_BW-1:0] den_q;

	logic last;
	logic [ARITH_BW:0] trial;
	logic ge;

	assign last = (op_q == OP_MUL) ? (cnt_q == STEP_W'(MUL_STEPS - 1))
	                               : (cnt_q == STEP_W'(DIV_STEPS - 1));
	assign trial = {rem_q[ARITH_BW-1:0], num_q[ARITH_AW-1]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			acc_q <= '0;
			mcand_q <= PROD_W'(req.a);
			mplier_q <= req.b;
			num_q <= req.a;
			rem_q <= '0;
			den_q <= req.b;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= {mcand_q[PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[ARITH_BW-1:1]};
			end else begin
				rem_q <= ge ? trial - {1'b0, den_q} : trial;
				num_q <= {num_q[ARITH_AW-2:0], ge};
			end
		end
	end

	assign done = done_q;
	assign result = (op_q == OP_MUL) ? acc_q : PROD_W'(num_q);

endmodule
`default_nettype wire

[verif/tb_piecewise_linear_interpolator_top.sv]
// Testbench for the piecewise linear interpolator, checked against a predictor.
module tb_piecewise_linear_interpolator_top;
	import plinterp_pkg::*;

	localparam int PERIOD_HALF = 10;
	localparam int IDLE_WAIT = 400;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int ITEM_TARGET = 450;

	typedef struct {
		logic [31:0] value;
		logic [31:0] slope;
		logic [1:0] region;
		logic sat;
	} interp_result_t;

	class interp_scoreboard;
		logic signed [31:0] tab_x[TABLE_DEPTH];
		logic signed [31:0] tab_y[TABLE_DEPTH];
		int unsigned count;
		logic signed [31:0] scale;
		interp_result_t expected_q[$];
		int errors;

		function new();
			count = 0;
			scale = SCALE_RESET;
			errors = 0;
		endfunction

		task report(string msg);
			if (errors < 40) begin
				$display("MISMATCH: %s", msg);
			end
			errors++;
		endtask

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			if (idx == CFG_POINT_COUNT) begin
				count = data[8:0];
			end else begin
				scale = data;
			end
		endfunction

		// floor(a * scale / 2^16), clipped to 32 bits
		function logic [31:0] scaled(logic signed [127:0] a, inout logic sat);
			logic signed [127:0] p;
			logic signed [127:0] s;
			logic signed [127:0] vmax;
			s = scale;
			vmax = 128'sh7FFF_FFFF;
			p = (a * s) >>> 16;
			if (p > vmax) begin
				sat = 1'b1;
				return 32'h7FFF_FFFF;
			end
			if (p < -vmax - 1) begin
				sat = 1'b1;
				return 32'h8000_0000;
			end
			return p[31:0];
		endfunction

		function interp_result_t evaluate(logic signed [31:0] q);
			int unsigned n;
			int unsigned lo;
			int unsigned len;
			int unsigned half;
			int unsigned ix;
			logic signed [127:0] x1, x2, y1, y2, dx, df, dq, t, f, d, lim;
			interp_result_t e;
			logic sat;
			n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
			sat = 1'b0;
			e.slope = '0;
			lim = 128'sh1_0000_0000_0000;
			if (n == 0) begin
				e.value = scaled(q, sat);
				e.slope = scale;
				e.region = REGION_EMPTY;
			end else begin
				ix = 0;
				if (n >= 2) begin
					lo = 0;
					len = n;
					while (len > 0) begin
						half = len >> 1;
						if (tab_x[lo + half] < q) begin
							lo = lo + half + 1;
							len = len - half - 1;
						end else begin
							len = half;
						end
					end
					ix = lo;
				end
				if (ix == 0) begin
					e.value = scaled(tab_y[0], sat);
					e.region = REGION_LOW;
				end else if (ix >= n) begin
					e.value = scaled(tab_y[n-1], sat);
					e.region = REGION_HIGH;
				end else begin
					x1 = tab_x[ix-1];
					x2 = tab_x[ix];
					y1 = tab_y[ix-1];
					y2 = tab_y[ix];
					dx = x2 - x1;
					df = y2 - y1;
					dq = q - x1;
					f = y1;
					d = 0;
					if (dx != 0) begin
						t = (df * dq) / dx;
						if (t > lim) t = lim;
						if (t < -lim) t = -lim;
						f = y1 + t;
						if (f > lim) f = lim;
						if (f < -lim) f = -lim;
						d = (df <<< 16) / dx;
					end
					e.value = scaled(f, sat);
					e.slope = scaled(d, sat);
					e.region = REGION_INT;
				end
			end
			e.sat = sat;
			return e;
		endfunction

		function void note_request(logic f, logic [7:0] idx, logic [31:0] px, logic [31:0] py,
				logic [31:0] qx);
			if (f == FUNC_WRITE) begin
				tab_x[idx] = px;
				tab_y[idx] = py;
			end else begin
				expected_q = {expected_q, evaluate(qx)};
			end
		endfunction

		task check_result(logic [31:0] v, logic [31:0] s, logic [1:0] r, logic st);
			interp_result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result value=%h", v));
				return;
			end
			e = expected_q.pop_front();
			if (v !== e.value) report($sformatf("value %h, want %h", v, e.value));
			if (s !== e.slope) report($sformatf("slope %h, want %h", s, e.slope));
			if (r !== e.region) report($sformatf("region %0d, want %0d", r, e.region));
			if (st !== e.sat) report($sformatf("saturated %b, want %b", st, e.sat));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic func;
	logic [7:0] point_index;
	logic [31:0] point_x;
	logic [31:0] point_y;
	logic [31:0] query_x;
	logic out_valid;
	logic out_stall;
	logic [31:0] value;
	logic [31:0] slope;
	logic [1:0] region;
	logic saturated;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	interp_scoreboard sb;
	longint cycles;
	int sent;
	bit hold_req;
	int cur_x[$];

	piecewise_linear_interpolator_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.point_index(point_index),
		.point_x(point_x),
		.point_y(point_y),
		.query_x(query_x),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.slope(slope),
		.region(region),
		.saturated(saturated),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#PERIOD_HALF;
		clk = 1'b1;
		#PERIOD_HALF;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_piecewise_linear_interpolator_top: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(value, slope, region, saturated);
		end
	end

	function automatic int pick_gap();
		int r;
		if ((cycles / 3000) % 4 == 0) return 0;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [31:0] pick_data();
		case ($urandom_range(4))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return 32'(int'($urandom_range(0, 2000)) - 1000) <<< 16;
			2: return 32'(int'($urandom_range(0, 200000)) - 100000);
			default: return $urandom;
		endcase
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (1500) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic send(input logic f, input logic [7:0] idx, input logic [31:0] px,
			input logic [31:0] py, input logic [31:0] qx);
		int gap;
		in_valid <= 1'b1;
		func <= f;
		point_index <= idx;
		point_x <= px;
		point_y <= py;
		query_x <= qx;
		do @(posedge clk); while (in_stall);
		sb.note_request(f, idx, px, py, qx);
		sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic evaluate_at(input logic [31:0] q);
		send(FUNC_EVAL, 8'($urandom), $urandom, $urandom, q);
	endtask

	task automatic write_point(input logic [7:0] idx, input logic [31:0] px, input logic [31:0] py);
		send(FUNC_WRITE, idx, px, py, $urandom);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.configure(idx, data);
		cfg_we <= 1'b0;
	endtask

	task automatic fill_table(input int n, input bit sorted);
		cur_x.delete();
		for (int i = 0; i < n; i++) cur_x = {cur_x, int'(pick_data())};
		if (sorted) cur_x.sort();
		for (int i = 0; i < n; i++) write_point(8'(i), cur_x[i], pick_data());
	endtask

	function automatic logic [31:0] pick_query();
		int k;
		longint span;
		if (cur_x.size() == 0) return pick_data();
		k = $urandom_range(0, cur_x.size() - 1);
		case ($urandom_range(3))
			0: return cur_x[k] + int'($urandom_range(0, 4)) - 2;
			1: begin
				if (k + 1 < cur_x.size()) begin
					span = longint'(cur_x[k+1]) - cur_x[k] + 1;
					if (span > 0) return 32'(cur_x[k] + longint'($urandom) % span);
				end
				return pick_data();
			end
			2: return cur_x[k];
			default: return pick_data();
		endcase
	endfunction

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(6))
			0: return SCALE_RESET;
			1: return '0;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'(int'($urandom_range(0, 8)) - 4) <<< 16;
			5: return 32'hFFFF_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int n;
		int phase;
		sb = new();
		cycles = 0;
		sent = 0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_WRITE;
		point_index = '0;
		point_x = '0;
		point_y = '0;
		query_x = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_POINT_COUNT;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		evaluate_at(32'h8000_0000);
		evaluate_at(32'h7FFF_FFFF);
		evaluate_at(32'h0000_0000);
		evaluate_at(32'hFFFF_FFFF);
		write_point(8'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		write_point(8'd1, 32'hFF9C_0000, 32'hFFFB_0000);
		write_point(8'd2, 32'h0000_0000, 32'h8000_0000);
		write_point(8'd3, 32'h0005_0000, 32'h0003_0000);
		write_point(8'd4, 32'h7FFF_FFFF, 32'h0000_0000);
		write_point(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// single point
		set_reg(CFG_POINT_COUNT, 32'd1);
		evaluate_at(32'h7FFF_FFFF);
		set_reg(CFG_POINT_COUNT, 32'd5);
		evaluate_at(32'h8000_0000);
		evaluate_at(32'h7FFF_FFFF);
		evaluate_at(32'hFFCE_0000);
		evaluate_at(32'h0002_0000);
		evaluate_at(32'hFFFF_0000);
		set_reg(CFG_SCALE_FACTOR, 32'h7FFF_FFFF);
		evaluate_at(32'h0003_0000);
		evaluate_at(32'h8000_0000);
		set_reg(CFG_SCALE_FACTOR, 32'h8000_0000);
		evaluate_at(32'hFFCE_0000);
		set_reg(CFG_POINT_COUNT, 32'd4);
		evaluate_at(32'h7FFF_FFFF);
		evaluate_at(32'h0004_0000);

		phase = 0;
		while (sent < ITEM_TARGET) begin
			if (phase == 2) n = TABLE_DEPTH;
			else begin
				case ($urandom_range(9))
					0: n = 0;
					1: n = 1;
					2: n = 2;
					3, 4: n = $urandom_range(9, 40);
					default: n = $urandom_range(3, 8);
				endcase
			end
			wait_idle();
			fill_table(n, $urandom_range(3) != 0);
			set_reg(CFG_POINT_COUNT, n);
			set_reg(CFG_SCALE_FACTOR, pick_scale());
			if (phase == 3) hold_req = 1'b1;
			repeat ($urandom_range(12, 30)) begin
				if ($urandom_range(9) == 0)
					write_point(8'($urandom), pick_data(), pick_data());
				else
					evaluate_at(pick_query());
			end
			phase++;
		end

		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb_piecewise_linear_interpolator_top: PASS");
		end else begin
			$display("tb_piecewise_linear_interpolator_top: FAIL");
		end
		$finish;
	end
endmodule

[piecewise_linear_interpolator_top.f]
rtl/core/plinterp_pkg.sv
rtl/core/plinterp_mem.sv
rtl/core/plinterp_arith.sv
rtl/core/piecewise_linear_interpolator_top.sv
verif/tb_piecewise_linear_interpolator_top.sv
